/* rtl/bfa_pkg.sv */
// Shared types, codes and helpers for the bitmap frame allocator.
package bfa_pkg;

	localparam int WORD_BITS  = 64;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 28;
	localparam int CFG_W      = 17;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 17'h10000;

	// request kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_INIT  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NOMEM  = 2'd1;
	localparam logic [1:0] STAT_DOUBLE = 2'd2;
	localparam logic [1:0] STAT_RANGE  = 2'd3;

	// configuration register indexes
	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_RESERVED    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_A_READ,
		ST_A_CHECK,
		ST_F_READ,
		ST_F_CHECK,
		ST_RESULT
	} state_t;

	// index of the lowest clear bit; zero when the word is full
	function automatic logic [5:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [5:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* rtl/bfa_map_ram.sv */
// Used-bit map store: one write port, one registered read port.
module bfa_map_ram #(
	parameter  int WORDS = 1024,
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [bfa_pkg::WORD_BITS-1:0]  wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [bfa_pkg::WORD_BITS-1:0]  rdata
);

	logic [bfa_pkg::WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bitmap_frame_allocator.sv */
// Bitmap page frame allocator: control, configuration and result register.
//
// Usage notes
// - Requests arrive on the s_ side: s_tuser carries the kind (allocate, free,
//   init), s_tdata the byte address to free. One result beat per request on
//   the m_ side: byte address of the allocated frame and a status code.
// - Configuration: cfg_we/cfg_index/cfg_wdata write frame_count (index 0) or
//   reserved_frames (index 1); write only while no request is outstanding.
// - One request at a time. The map is one word of 64 used bits per RAM entry,
//   read-modify-written through a registered read port.
//   Allocate: map words are read one by one until one has a clear bit, or
//   until the scan runs off the map or past the frame count; the scan
//   starts at a hint word (all lower words known full).
//   Free: one word read, checked and written back, or none for an out-of-range
//   address. Init: one map word written per cycle. Unused kind: no map access.
// - Reset: a clearing sweep writes zero to every map word; s_tready stays low
//   until it ends, config writes are taken throughout.
// - Stall: the result sits in an output register. The next request is taken
//   while it waits; that request's result waits in turn until the register is
//   taken, and s_tready stays low meanwhile.
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // [31:0] frame_address
	input  logic [1:0]                s_tuser,   // [1:0] kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata    // [27:0] address, [29:28] status, [31:30] zero
);

	localparam int MAP_WORDS = (MAX_FRAMES + 63) / 64;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W     = 33;
	localparam int WB        = bfa_pkg::WORD_BITS;
	localparam logic [AW:0] LAST_WORD = (AW + 1)'(MAP_WORDS - 1);
	localparam logic [AW:0] MAP_END   = (AW + 1)'(MAP_WORDS);

	bfa_pkg::state_t state_q, state_d;

	// configuration
	logic [bfa_pkg::CFG_W-1:0] frame_count_q, reserved_q;
	logic [CNT_W-1:0]          count_eff, reserve_eff;

	// control
	logic [AW:0]        ptr_q;        // sweep / scan word pointer
	logic [AW:0]        hint_q;       // every word below this is full
	logic [CNT_W-1:0]   res_n_q;      // frames the current sweep marks used
	logic               sweep_reply_q;
	logic               out_valid_q;

	// payload
	logic [AW-1:0]              free_word_q;
	logic [5:0]                 free_bit_q;
	logic [bfa_pkg::ADDR_W-1:0] res_addr_q, out_addr_q;
	logic [1:0]                 res_status_q, out_status_q;

	// memory port
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [WB-1:0] mem_wdata, rdata;

	// decode
	logic [19:0]     frame_in;
	logic            in_range;
	logic            accept;
	logic            out_load;
	logic            scan_end;
	logic            word_full;
	logic [5:0]      zb;
	logic [AW+5:0]   cand;
	logic            cand_ok;
	logic [63:0]     cand_byte;
	logic [WB-1:0]   sweep_word;
	logic [5:0]      rest;

	assign count_eff = (CMP_W'(frame_count_q) > CMP_W'(MAX_FRAMES)) ?
		CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_q);
	assign reserve_eff = (CMP_W'(reserved_q) > CMP_W'(MAX_FRAMES)) ?
		CNT_W'(MAX_FRAMES) : CNT_W'(reserved_q);

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == bfa_pkg::ST_RESULT) && (!out_valid_q || m_tready);

	// unaligned addresses: low 12 bits dropped
	assign frame_in = s_tdata[31:bfa_pkg::PAGE_SHIFT];
	assign in_range = CMP_W'(frame_in) < CMP_W'(count_eff);

	// scan stops at the end of the map or once a word starts past the count
	assign scan_end = (ptr_q == MAP_END) || (CMP_W'({ptr_q, 6'b0}) >= CMP_W'(count_eff));

	assign word_full = &rdata;
	assign zb        = bfa_pkg::lowest_zero(rdata);
	assign cand      = {ptr_q[AW-1:0], zb};
	assign cand_ok   = CMP_W'(cand) < CMP_W'(count_eff);
	assign cand_byte = 64'({cand, 12'b0});

	// sweep fill: whole words below the reserved count, a partial mask at it
	assign rest = res_n_q[5:0];
	always_comb begin
		if (CMP_W'(ptr_q) < CMP_W'(res_n_q >> 6)) begin
			sweep_word = '1;
		end else if (CMP_W'(ptr_q) == CMP_W'(res_n_q >> 6)) begin
			sweep_word = (WB'(1) << rest) - WB'(1);
		end else begin
			sweep_word = '0;
		end
	end

	bfa_map_ram #(
		.WORDS (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						bfa_pkg::KIND_ALLOC: state_d = bfa_pkg::ST_A_READ;
						bfa_pkg::KIND_FREE:  state_d = in_range ? bfa_pkg::ST_F_READ
						                                        : bfa_pkg::ST_RESULT;
						bfa_pkg::KIND_INIT:  state_d = bfa_pkg::ST_SWEEP;
						default:             state_d = bfa_pkg::ST_RESULT;
					endcase
				end
			end
			bfa_pkg::ST_SWEEP: begin
				if (ptr_q == LAST_WORD) begin
					state_d = sweep_reply_q ? bfa_pkg::ST_RESULT : bfa_pkg::ST_IDLE;
				end
			end
			bfa_pkg::ST_A_READ:  state_d = scan_end ? bfa_pkg::ST_RESULT : bfa_pkg::ST_A_CHECK;
			bfa_pkg::ST_A_CHECK: state_d = word_full ? bfa_pkg::ST_A_READ : bfa_pkg::ST_RESULT;
			bfa_pkg::ST_F_READ:  state_d = bfa_pkg::ST_F_CHECK;
			bfa_pkg::ST_F_CHECK: state_d = bfa_pkg::ST_RESULT;
			bfa_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			default: state_d = bfa_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake and memory port. Accesses never overlap: each write
	// is done before the next read is issued.
	always_comb begin
		s_tready  = (state_q == bfa_pkg::ST_IDLE);
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_raddr = ptr_q[AW-1:0];
		mem_wdata = '0;
		case (state_q)
			bfa_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_wdata = sweep_word;
			end
			bfa_pkg::ST_A_READ: begin
				mem_re = !scan_end;
			end
			bfa_pkg::ST_A_CHECK: begin
				mem_we    = !word_full && cand_ok;
				mem_wdata = rdata | (WB'(1) << zb);
			end
			bfa_pkg::ST_F_READ: begin
				mem_re    = 1'b1;
				mem_raddr = free_word_q;
			end
			bfa_pkg::ST_F_CHECK: begin
				mem_we    = rdata[free_bit_q];
				mem_waddr = free_word_q;
				mem_wdata = rdata & ~(WB'(1) << free_bit_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bfa_pkg::ST_SWEEP;   // clearing sweep after reset
			ptr_q         <= '0;
			hint_q        <= '0;
			res_n_q       <= '0;
			sweep_reply_q <= 1'b0;
			out_valid_q   <= 1'b0;
			frame_count_q <= bfa_pkg::FRAME_COUNT_RESET;
			reserved_q    <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					bfa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_wdata;
					bfa_pkg::REG_RESERVED:    reserved_q    <= cfg_wdata;
					default:                  reserved_q    <= reserved_q;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				bfa_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == bfa_pkg::KIND_INIT) begin
							ptr_q         <= '0;
							res_n_q       <= reserve_eff;
							sweep_reply_q <= 1'b1;
						end else begin
							ptr_q <= hint_q;
						end
					end
				end
				bfa_pkg::ST_SWEEP: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_WORD) begin
						hint_q <= (AW + 1)'(res_n_q >> 6);
					end
				end
				bfa_pkg::ST_A_CHECK: begin
					if (word_full) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (cand_ok) begin
						hint_q <= ptr_q;
					end
				end
				bfa_pkg::ST_F_CHECK: begin
					if (rdata[free_bit_q] && ((AW + 1)'(free_word_q) < hint_q)) begin
						hint_q <= (AW + 1)'(free_word_q);
					end
				end
				default: begin
					hint_q <= hint_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			bfa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					free_word_q <= AW'(frame_in >> 6);
					free_bit_q  <= frame_in[5:0];
					res_addr_q  <= '0;
					res_status_q <= (s_tuser == bfa_pkg::KIND_FREE && !in_range) ?
						bfa_pkg::STAT_RANGE : bfa_pkg::STAT_OK;
				end
			end
			bfa_pkg::ST_A_READ: begin
				if (scan_end) begin
					res_status_q <= bfa_pkg::STAT_NOMEM;
				end
			end
			bfa_pkg::ST_A_CHECK: begin
				if (!word_full) begin
					if (cand_ok) begin
						res_addr_q <= cand_byte[bfa_pkg::ADDR_W-1:0];
					end else begin
						res_status_q <= bfa_pkg::STAT_NOMEM;
					end
				end
			end
			bfa_pkg::ST_F_CHECK: begin
				if (!rdata[free_bit_q]) begin
					res_status_q <= bfa_pkg::STAT_DOUBLE;
				end
			end
			default: begin
				res_addr_q <= res_addr_q;
			end
		endcase

		if (out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_status_q, out_addr_q};

	// a taken request holds the port closed for at least the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while another is in flight");

	// map writes happen only in the sweep and the two check states
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == bfa_pkg::ST_SWEEP || state_q == bfa_pkg::ST_A_CHECK ||
		            state_q == bfa_pkg::ST_F_CHECK))
		else $error("map write outside a write state");

	// hint never points past the end of the map
	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= MAP_END)
		else $error("scan hint beyond map");

	// any failure result (status other than OK) carries a zero address
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_status_q != bfa_pkg::STAT_OK) |-> (out_addr_q == '0))
		else $error("non-zero address on error result");

endmodule

/* sim/frame_result_checker.sv */
// Request/result monitor for the bitmap frame allocator: predicts and checks every result beat.
module frame_result_checker #(
	parameter int MAX_FRAMES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [31:0]               s_tdata,   // [31:0] frame_address
	input  logic [1:0]                s_tuser,   // [1:0] kind
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [31:0]               m_tdata,   // [27:0] address, [29:28] status, [31:30] zero
	output int                        pending_results,
	output int                        error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_WORDS = (MAX_FRAMES + 63) / 64;

	typedef struct packed {
		logic [bfa_pkg::ADDR_W-1:0] address;
		logic [1:0]                 status;
	} frame_result_t;

	logic [bfa_pkg::WORD_BITS-1:0] used_words [MAP_WORDS];
	logic [bfa_pkg::CFG_W-1:0]     frame_limit;
	logic [bfa_pkg::CFG_W-1:0]     reserve_limit;
	frame_result_t                 due_results [$];

	function automatic int clamp_frames(input logic [bfa_pkg::CFG_W-1:0] n);
		return (int'(n) > MAX_FRAMES) ? MAX_FRAMES : int'(n);
	endfunction

	// init: wipe the map, then mark frames below the reserved count
	task automatic rebuild_map();
		int marked;
		marked = clamp_frames(reserve_limit);
		for (int w = 0; w < MAP_WORDS; w++) begin
			if (w * 64 + 64 <= marked) begin
				used_words[w] = '1;
			end else if (w * 64 < marked) begin
				used_words[w] = (64'd1 << (marked - w * 64)) - 64'd1;
			end else begin
				used_words[w] = '0;
			end
		end
	endtask

	task automatic service_request(input logic [1:0] kind, input logic [31:0] byte_addr,
			output frame_result_t res);
		int                            count;
		int                            frame;
		int                            b;
		bit                            found;
		logic [bfa_pkg::WORD_BITS-1:0] word;
		res.address = '0;
		res.status  = bfa_pkg::STAT_OK;
		count = clamp_frames(frame_limit);
		case (kind)
		bfa_pkg::KIND_ALLOC: begin
			res.status = bfa_pkg::STAT_NOMEM;
			found = 1'b0;
			// first word with a clear bit decides: beyond the count means no memory
			for (int w = 0; w < MAP_WORDS && !found; w++) begin
				word = used_words[w];
				if (word != '1) begin
					found = 1'b1;
					b = 0;
					while (word[b]) begin
						b++;
					end
					if (w * 64 + b < count) begin
						used_words[w][b] = 1'b1;
						res.address = bfa_pkg::ADDR_W'(longint'(w * 64 + b)
							<< bfa_pkg::PAGE_SHIFT);
						res.status  = bfa_pkg::STAT_OK;
					end
				end
			end
		end
		bfa_pkg::KIND_FREE: begin
			frame = int'(byte_addr >> bfa_pkg::PAGE_SHIFT);
			if (frame >= count) begin
				res.status = bfa_pkg::STAT_RANGE;
			end else if (!used_words[frame / 64][frame % 64]) begin
				res.status = bfa_pkg::STAT_DOUBLE;
			end else begin
				used_words[frame / 64][frame % 64] = 1'b0;
			end
		end
		bfa_pkg::KIND_INIT: begin
			rebuild_map();
		end
		default: begin
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				used_words[w] = '0;
			end
			frame_limit   = bfa_pkg::FRAME_COUNT_RESET;
			reserve_limit = '0;
			due_results.delete();
			error_count   = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bfa_pkg::REG_FRAME_COUNT) begin
					frame_limit = cfg_wdata;
				end else begin
					reserve_limit = cfg_wdata;
				end
			end
			if (m_tvalid && m_tready) begin
				got.address = m_tdata[bfa_pkg::ADDR_W-1:0];
				got.status  = m_tdata[bfa_pkg::ADDR_W+1:bfa_pkg::ADDR_W];
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_tdata);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (got.address !== want.address) begin
						$display("%0t: address expected %h got %h", $time, want.address,
							got.address);
						error_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %h got %h", $time, want.status,
							got.status);
						error_count++;
					end
				end
				if (m_tdata[31:bfa_pkg::ADDR_W+2] !== '0) begin
					$display("%0t: padding expected 0 got %h", $time,
						m_tdata[31:bfa_pkg::ADDR_W+2]);
					error_count++;
				end
			end
			if (s_tvalid && s_tready) begin
				service_request(s_tuser, s_tdata, want);
				due_results.push_back(want);
			end
		end
		pending_results = due_results.size();
	end

endmodule

/* sim/bitmap_frame_allocator_test.sv */
// Stimulus, back-pressure and verdict for the bitmap frame allocator.
module bitmap_frame_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD    = 10;
	localparam int          RESET_CYCLES  = 7;
	localparam int          ITEM_TARGET   = 750;
	// idle margin before a register write, and drain time at the end
	localparam int          SETTLE_CYCLES = 4;
	localparam int          DRAIN_CYCLES  = 64;
	// worst case: every beat scanning the whole map plus the longest gap and stall,
	// and the clearing sweep after reset, then about four times over
	localparam int unsigned CYCLE_LIMIT   = 8_000_000;
	localparam int          PICK_SPAN     = 300;
	// no package code for the spare kind
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [bfa_pkg::CFG_W-1:0] cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [31:0]               s_tdata;   // [31:0] frame_address
	logic [1:0]                s_tuser;   // [1:0] kind
	logic                      m_tvalid;
	logic                      m_tready;
	logic [31:0]               m_tdata;   // [27:0] address, [29:28] status, [31:30] zero

	int               pending_results;
	int               error_count;
	int               beats_sent;
	int unsigned      cycle_count;
	bit               steady_sender;
	int               frame_setting;   // frame count last written, as the block clamps it
	int               stall_left;
	int               calm_left;

	bitmap_frame_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	frame_result_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.pending_results (pending_results),
		.error_count     (error_count)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short pauses, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(1, 2);
		end else if (r < 90) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 80);
	endfunction

	// result side: random stalls, with calm stretches of full throughput
	always @(posedge clk) begin
		if (calm_left > 0) begin
			calm_left--;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 299) == 0) begin
				calm_left = $urandom_range(100, 400);
			end else if ($urandom_range(0, 2) == 0) begin
				stall_left = pause_len();
			end
		end
	end

	// one request beat; returns in the time step of the handshake, valid still high
	task automatic send_request(input logic [1:0] kind, input logic [31:0] byte_addr);
		int gap;
		gap = (steady_sender || $urandom_range(0, 99) < 45) ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= byte_addr;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// every result back, then a small margin so the block is truly idle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [bfa_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [bfa_pkg::CFG_W-1:0] frames,
			input logic [bfa_pkg::CFG_W-1:0] reserved);
		wait_idle();
		write_reg(bfa_pkg::REG_FRAME_COUNT, frames);
		write_reg(bfa_pkg::REG_RESERVED, reserved);
		cfg_we <= 1'b0;
		frame_setting = (int'(frames) > 65536) ? 65536 : int'(frames);
	endtask

	task automatic send_free(input int frame);
		send_request(bfa_pkg::KIND_FREE, {20'(frame), 12'($urandom())});
	endtask

	// one setting, usually a fresh map, then a run of mostly well-formed traffic
	task automatic run_phase();
		int                        r;
		int                        span;
		int                        n;
		logic [bfa_pkg::CFG_W-1:0] frames;
		logic [bfa_pkg::CFG_W-1:0] reserved;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			case ($urandom_range(0, 7))
			0: frames = 17'd0;
			1: frames = 17'd1;
			2: frames = 17'd2;
			3: frames = 17'd63;
			4: frames = 17'd64;
			5: frames = 17'd65;
			6: frames = 17'd128;
			default: frames = 17'd129;
			endcase
		end else if (r < 70) begin
			frames = 17'($urandom_range(1, PICK_SPAN));
		end else if (r < 80) begin
			frames = bfa_pkg::FRAME_COUNT_RESET;
		end else if (r < 85) begin
			frames = '1;
		end else begin
			frames = 17'($urandom());
		end
		span = (int'(frames) > PICK_SPAN) ? PICK_SPAN : int'(frames);
		case ($urandom_range(0, 9))
		0: reserved = '0;
		1: reserved = frames;
		2: reserved = '1;
		3: reserved = 17'($urandom());
		default: reserved = 17'($urandom_range(0, span + 5));
		endcase
		configure(frames, reserved);
		steady_sender = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 4) != 0) begin
			send_request(bfa_pkg::KIND_INIT, $urandom());
		end
		n = $urandom_range(15, 50);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_request(bfa_pkg::KIND_ALLOC, $urandom());
			end else if (r < 80) begin
				send_free((span > 0) ? $urandom_range(0, span - 1) : 0);
			end else if (r < 88) begin
				// just past the managed range
				send_free(frame_setting + $urandom_range(0, 3));
			end else if (r < 94) begin
				send_request(bfa_pkg::KIND_FREE, $urandom());
			end else if (r < 97) begin
				send_request(bfa_pkg::KIND_INIT, $urandom());
			end else begin
				send_request(KIND_UNUSED, $urandom());
			end
		end
	endtask

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= bfa_pkg::KIND_ALLOC;
		cfg_we    <= 1'b0;
		cfg_index <= bfa_pkg::REG_FRAME_COUNT;
		cfg_wdata <= '0;
		m_tready  <= 1'b0;
		arst_n    <= 1'b0;
		frame_setting = 65536;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: full capacity, nothing reserved; first beat waits out the sweep
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_ALLOC, 32'hFFFF_FFFF);
		send_request(bfa_pkg::KIND_FREE, 32'h0000_0000);
		send_request(bfa_pkg::KIND_FREE, 32'h0000_0000);      // double free
		send_request(bfa_pkg::KIND_FREE, 32'h0000_1FFF);      // unaligned, frame 1
		send_request(bfa_pkg::KIND_FREE, 32'h0FFF_F000);      // top frame, never taken
		send_request(bfa_pkg::KIND_FREE, 32'h1000_0000);      // first frame past capacity
		send_request(bfa_pkg::KIND_FREE, 32'hFFFF_FFFF);
		send_request(KIND_UNUSED, 32'hA5A5_5A5A);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);

		// all but the top frame reserved: highest address, then exhaustion
		configure(17'h10000, 17'h0FFFF);
		send_request(bfa_pkg::KIND_INIT, 32'h0);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_FREE, 32'h0FFF_F123);

		// both registers beyond capacity: clamped
		configure('1, '1);
		send_request(bfa_pkg::KIND_INIT, 32'h0);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_FREE, 32'h0000_0000);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);

		// nothing managed
		configure('0, '0);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_FREE, 32'h0000_0000);
		send_request(bfa_pkg::KIND_INIT, 32'h0);

		// reserved beyond the frame count
		configure(17'd100, 17'd200);
		send_request(bfa_pkg::KIND_INIT, 32'h0);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);
		send_request(bfa_pkg::KIND_FREE, 32'h0006_3000);
		send_request(bfa_pkg::KIND_ALLOC, 32'h0);

		while (beats_sent < ITEM_TARGET) begin
			run_phase();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
